// ----- src/hd_pkg.sv -----
package hd_pkg;

	// Default number of CORDIC iterations.
	localparam int unsigned CORDIC_STEPS_DEF = 28;

	// Angle width inside the CORDICs (Q32 radians, signed).
	localparam int ZW = 37;
	// Width of the CORDIC x/y datapath (Q30, signed).
	localparam int XW = 35;
	// Width of the haversine term and of the square roots (Q30, unsigned, up to 1.0).
	localparam int AW = 31;
	// Width of the central angle in Q32 out of the vectoring CORDIC.
	localparam int CW = 34;
	// Width of the radius register.
	localparam int RW = 23;

	localparam logic signed [ZW-1:0] PI_Q32 = 37'sd13493037704;
	localparam logic signed [ZW-1:0] HALF_PI_Q32 = 37'sd6746518852;
	localparam logic signed [ZW-1:0] QUARTER_PI_Q32 = 37'sd3373259426;
	localparam logic signed [XW-1:0] GAIN_Q30 = 35'sd652032874;
	localparam logic [AW-1:0] ONE_Q30 = 31'd1073741824;
	localparam logic [RW-1:0] RADIUS_RST = 23'd6371000;

	// atan(2^-i) in Q32, from the odd power series in Q62 rounded to Q32.
	// The series terms are divided by a bitwise long division at elaboration.
	function automatic logic signed [ZW-1:0] atan_q32(input int unsigned i);
		logic signed [63:0] sum;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] quo;
		int unsigned k;
		int unsigned e;
		int unsigned d;
		int unsigned b;
		sum = '0;
		if (i == 0) begin
			return QUARTER_PI_Q32;
		end
		for (k = 0; i * (2 * k + 1) <= 62; k++) begin
			e = 62 - i * (2 * k + 1);
			d = 2 * k + 1;
			num = 64'd1 << e;
			rem = '0;
			quo = '0;
			for (b = 0; b < 64; b++) begin
				rem = {rem[62:0], num[63-b]};
				if (rem >= 64'(d)) begin
					rem = rem - 64'(d);
					quo[63-b] = 1'b1;
				end
			end
			if ((k % 2) == 1) begin
				sum = sum - signed'(quo);
			end else begin
				sum = sum + signed'(quo);
			end
		end
		sum = (sum + 64'sd536870912) >>> 30;
		return sum[ZW-1:0];
	endfunction

endpackage

// ----- src/hd_sin_cos.sv -----
module hd_sin_cos #(
	parameter int unsigned STEPS = 28
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            vld_in,
	input  logic signed [hd_pkg::ZW-1:0]    z_in,
	output logic                            vld_out,
	output logic signed [hd_pkg::XW-1:0]    sin_out,
	output logic signed [hd_pkg::XW-1:0]    cos_out
);
	import hd_pkg::*;

	localparam int unsigned NR = 3;

	logic                  vld_s [0:NR+STEPS];
	logic signed [ZW-1:0]  zr_s  [0:NR];
	logic                  fr_s  [0:NR];
	logic signed [ZW-1:0]  zc_s  [0:STEPS];
	logic signed [XW-1:0]  xc_s  [0:STEPS];
	logic signed [XW-1:0]  yc_s  [0:STEPS];
	logic                  fc_s  [0:STEPS];

	assign vld_s[0] = vld_in;
	assign zr_s[0]  = z_in;
	assign fr_s[0]  = 1'b0;
	assign zc_s[0]  = zr_s[NR];
	assign fc_s[0]  = fr_s[NR];
	assign xc_s[0]  = GAIN_Q30;
	assign yc_s[0]  = '0;

	for (genvar g = 0; g < NR + STEPS; g++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
	end

	// Each reduction step folds an angle beyond plus or minus pi/2 by pi and flips the output signs.
	for (genvar n = 0; n < NR; n++) begin : g_red
		always_ff @(posedge clk) begin
			if (zr_s[n] > HALF_PI_Q32) begin
				zr_s[n+1] <= zr_s[n] - PI_Q32;
				fr_s[n+1] <= ~fr_s[n];
			end else if (zr_s[n] < -HALF_PI_Q32) begin
				zr_s[n+1] <= zr_s[n] + PI_Q32;
				fr_s[n+1] <= ~fr_s[n];
			end else begin
				zr_s[n+1] <= zr_s[n];
				fr_s[n+1] <= fr_s[n];
			end
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_rot
		localparam logic signed [ZW-1:0] AT = atan_q32(j);
		always_ff @(posedge clk) begin
			if (!zc_s[j][ZW-1]) begin
				xc_s[j+1] <= xc_s[j] - (yc_s[j] >>> j);
				yc_s[j+1] <= yc_s[j] + (xc_s[j] >>> j);
				zc_s[j+1] <= zc_s[j] - AT;
			end else begin
				xc_s[j+1] <= xc_s[j] + (yc_s[j] >>> j);
				yc_s[j+1] <= yc_s[j] - (xc_s[j] >>> j);
				zc_s[j+1] <= zc_s[j] + AT;
			end
			fc_s[j+1] <= fc_s[j];
		end
	end

	assign vld_out = vld_s[NR+STEPS];
	assign sin_out = fc_s[STEPS] ? -yc_s[STEPS] : yc_s[STEPS];
	assign cos_out = fc_s[STEPS] ? -xc_s[STEPS] : xc_s[STEPS];

endmodule

// ----- src/hd_hav.sv -----
module hd_hav (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_in,
	input  logic signed [hd_pkg::XW-1:0]  s_lat,
	input  logic signed [hd_pkg::XW-1:0]  s_lon,
	input  logic signed [hd_pkg::XW-1:0]  c_a,
	input  logic signed [hd_pkg::XW-1:0]  c_b,
	output logic                          vld_out,
	output logic [hd_pkg::AW-1:0]         hav_out
);
	import hd_pkg::*;

	localparam int PW = 2 * XW;

	// Round a Q60 product to Q30: add half an LSB, then floor shift.
	function automatic logic signed [XW-1:0] rnd30(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = (p + (PW'(1) <<< 29)) >>> 30;
		return t[XW-1:0];
	endfunction

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [PW-1:0] plat_s1, plon_s1, pcc_s1;
	logic signed [XW-1:0] sl_s2, sn_s2, cc_s2;
	logic signed [XW-1:0] sl_s3;
	logic signed [PW-1:0] m_s3;
	logic [AW-1:0]        hav_s4;
	logic signed [XW-1:0] mr;
	logic signed [XW:0]   sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign mr  = rnd30(m_s3);
	assign sum = {sl_s3[XW-1], sl_s3} + {mr[XW-1], mr};

	always_ff @(posedge clk) begin
		plat_s1 <= PW'(s_lat) * PW'(s_lat);
		plon_s1 <= PW'(s_lon) * PW'(s_lon);
		pcc_s1  <= PW'(c_a) * PW'(c_b);
		sl_s2   <= rnd30(plat_s1);
		sn_s2   <= rnd30(plon_s1);
		cc_s2   <= rnd30(pcc_s1);
		sl_s3   <= sl_s2;
		m_s3    <= PW'(cc_s2) * PW'(sn_s2);
		if (sum[XW]) begin
			hav_s4 <= '0;
		end else if (sum > (XW+1)'(ONE_Q30)) begin
			hav_s4 <= ONE_Q30;
		end else begin
			hav_s4 <= sum[AW-1:0];
		end
	end

	assign vld_out = vld_s4;
	assign hav_out = hav_s4;

endmodule

// ----- src/hd_isqrt.sv -----
module hd_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vld_in,
	input  logic [hd_pkg::AW-1:0]  val_in,
	output logic                   vld_out,
	output logic [hd_pkg::AW-1:0]  root_out
);
	import hd_pkg::*;

	// Floor square root of val_in * 2^30, one result bit per stage.
	localparam int NS = AW;
	localparam int DW = 2 * AW;
	localparam int MW = AW + 3;

	logic           vld_s  [0:NS];
	logic [DW-1:0]  rad_s  [0:NS];
	logic [MW-1:0]  rem_s  [0:NS];
	logic [AW-1:0]  root_s [0:NS];

	assign vld_s[0]  = vld_in;
	assign rad_s[0]  = {1'b0, val_in, 30'd0};
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < NS; k++) begin : g_dig
		logic [MW-1:0] nxt;
		logic [MW-1:0] trial;
		assign nxt   = {rem_s[k][MW-3:0], rad_s[k][DW-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1] <= {rad_s[k][DW-3:0], 2'b00};
			if (nxt >= trial) begin
				rem_s[k+1]  <= nxt - trial;
				root_s[k+1] <= {root_s[k][AW-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= nxt;
				root_s[k+1] <= {root_s[k][AW-2:0], 1'b0};
			end
		end
	end

	assign vld_out  = vld_s[NS];
	assign root_out = root_s[NS];

endmodule

// ----- src/hd_vec.sv -----
module hd_vec #(
	parameter int unsigned STEPS = 28
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vld_in,
	input  logic [hd_pkg::AW-1:0]  x_in,
	input  logic [hd_pkg::AW-1:0]  y_in,
	output logic                   vld_out,
	output logic [hd_pkg::CW-1:0]  ang_out
);
	import hd_pkg::*;

	logic                  vld_s [0:STEPS];
	logic signed [XW-1:0]  x_s   [0:STEPS];
	logic signed [XW-1:0]  y_s   [0:STEPS];
	logic signed [ZW-1:0]  z_s   [0:STEPS];
	logic signed [ZW-1:0]  zf;

	assign vld_s[0] = vld_in;
	assign x_s[0]   = XW'(x_in);
	assign y_s[0]   = XW'(y_in);
	assign z_s[0]   = '0;

	for (genvar j = 0; j < STEPS; j++) begin : g_vec
		localparam logic signed [ZW-1:0] AT = atan_q32(j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (!y_s[j][XW-1] && (y_s[j] != '0)) begin
				x_s[j+1] <= x_s[j] + (y_s[j] >>> j);
				y_s[j+1] <= y_s[j] - (x_s[j] >>> j);
				z_s[j+1] <= z_s[j] + AT;
			end else begin
				x_s[j+1] <= x_s[j] - (y_s[j] >>> j);
				y_s[j+1] <= y_s[j] + (x_s[j] >>> j);
				z_s[j+1] <= z_s[j] - AT;
			end
		end
	end

	// Half angle doubled; a small negative residue reads as zero.
	assign zf      = z_s[STEPS];
	assign vld_out = vld_s[STEPS];
	assign ang_out = zf[ZW-1] ? '0 : {zf[CW-2:0], 1'b0};

endmodule

// ----- src/haversine_distance.sv -----
// Channel        Direction  Handshake            Payload
// request        in         start / busy         lat_a, lon_a, lat_b, lon_b
// result         out        done (one cycle)     central_angle, distance_q8
// radius write   in         wr_en                wr_data
//
// The pipeline takes one request in every cycle; busy is held low.
// Each result follows its request through the input stage, the two CORDIC chains (one stage
// per iteration), the haversine stages, the 31-stage square root and the output stages.
// The receiver cannot stall; results are strobed by done for exactly one cycle.
// Reset clears all valid bits and loads the radius with the mean Earth radius.
module haversine_distance #(
	parameter int unsigned CORDIC_STEPS = hd_pkg::CORDIC_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [29:0]           lat_a,
	input  logic signed [30:0]           lon_a,
	input  logic signed [29:0]           lat_b,
	input  logic signed [30:0]           lon_b,
	output logic                         done,
	output logic [29:0]                  central_angle,
	output logic [32:0]                  distance_q8,
	input  logic                         wr_en,
	input  logic [hd_pkg::RW-1:0]        wr_data
);
	import hd_pkg::*;

	localparam int HW = 17;
	localparam int PW = HW + RW;

	// The radius register; the user must write it only while the pipeline is empty, the block does not enforce this.
	logic [RW-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
		end else if (wr_en) begin
			radius_q <= wr_data;
		end
	end

	// Every request is accepted, so busy never rises.
	assign busy = 1'b0;

	// Input stage: the half differences and the full latitudes, all as Q32 angles.
	// A Q28 half angle is a left shift by three, a Q28 full angle a shift by four.
	logic                 vld_s1;
	logic signed [ZW-1:0] zlat_s1, zlon_s1, za_s1, zb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		zlat_s1 <= (ZW'(lat_b) - ZW'(lat_a)) <<< 3;
		zlon_s1 <= (ZW'(lon_b) - ZW'(lon_a)) <<< 3;
		za_s1   <= ZW'(lat_a) <<< 4;
		zb_s1   <= ZW'(lat_b) <<< 4;
	end

	// Four rotation CORDIC lanes running in lockstep. Only the sines of the half
	// differences and the cosines of the latitudes are used further on.
	logic                 vld_sc;
	logic signed [XW-1:0] s_lat, s_lon, c_a, c_b;

	hd_sin_cos #(.STEPS(CORDIC_STEPS)) u_sc_lat (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .z_in(zlat_s1),
		.vld_out(vld_sc), .sin_out(s_lat), .cos_out()
	);

	hd_sin_cos #(.STEPS(CORDIC_STEPS)) u_sc_lon (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .z_in(zlon_s1),
		.vld_out(), .sin_out(s_lon), .cos_out()
	);

	hd_sin_cos #(.STEPS(CORDIC_STEPS)) u_sc_a (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .z_in(za_s1),
		.vld_out(), .sin_out(), .cos_out(c_a)
	);

	hd_sin_cos #(.STEPS(CORDIC_STEPS)) u_sc_b (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .z_in(zb_s1),
		.vld_out(), .sin_out(), .cos_out(c_b)
	);

	// Haversine term, clamped to the range from zero to one.
	logic          vld_hv;
	logic [AW-1:0] hav;

	hd_hav u_hav (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_sc),
		.s_lat(s_lat), .s_lon(s_lon), .c_a(c_a), .c_b(c_b),
		.vld_out(vld_hv), .hav_out(hav)
	);

	// Square roots of a and of 1 - a, both in Q30.
	logic          vld_rt;
	logic [AW-1:0] root_a, root_b;

	hd_isqrt u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_hv), .val_in(hav),
		.vld_out(vld_rt), .root_out(root_a)
	);

	hd_isqrt u_sqrt_b (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_hv), .val_in(ONE_Q30 - hav),
		.vld_out(), .root_out(root_b)
	);

	// Vectoring CORDIC gives atan2(sqrt(a), sqrt(1 - a)); the module doubles it.
	logic          vld_vc;
	logic [CW-1:0] c_q32;

	hd_vec #(.STEPS(CORDIC_STEPS)) u_vec (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_rt), .x_in(root_b), .y_in(root_a),
		.vld_out(vld_vc), .ang_out(c_q32)
	);

	// Output stage one: the angle is rounded to Q28, and the distance product is
	// split into two narrow partial products on the upper and lower angle bits.
	logic          vld_o1;
	logic [CW:0]   ang_rnd;
	logic [29:0]   ang_o1;
	logic [PW-1:0] ph_o1, pl_o1;

	assign ang_rnd = ((CW+1)'(c_q32) + (CW+1)'(8)) >> 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o1 <= 1'b0;
		end else begin
			vld_o1 <= vld_vc;
		end
	end

	always_ff @(posedge clk) begin
		if (ang_rnd > (CW+1)'(30'h3FFFFFFF)) begin
			ang_o1 <= 30'h3FFFFFFF;
		end else begin
			ang_o1 <= ang_rnd[29:0];
		end
		ph_o1 <= PW'(c_q32[CW-1:HW]) * PW'(radius_q);
		pl_o1 <= PW'(c_q32[HW-1:0]) * PW'(radius_q);
	end

	// Output stage two: the partial products are joined and rounded to Q8, then
	// the distance saturates at the top of its field.
	localparam int SW = CW + RW + 1;

	logic [SW-1:0] prod;
	logic [SW-1:0] dist_rnd;
	logic          done_q;
	logic [29:0]   ang_q;
	logic [32:0]   dist_q;

	assign prod     = (SW'(ph_o1) << HW) + SW'(pl_o1);
	assign dist_rnd = (prod + (SW'(1) << 23)) >> 24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_o1;
		end
	end

	always_ff @(posedge clk) begin
		ang_q <= ang_o1;
		if (dist_rnd > SW'(33'h1FFFFFFFF)) begin
			dist_q <= 33'h1FFFFFFFF;
		end else begin
			dist_q <= dist_rnd[32:0];
		end
	end

	assign done          = done_q;
	assign central_angle = ang_q;
	assign distance_q8   = dist_q;

endmodule

// ----- src/hd_checker.sv -----
module hd_checker #(
	parameter int unsigned CORDIC_STEPS = hd_pkg::CORDIC_STEPS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done
);
	localparam int unsigned LAT = 41 + 2 * CORDIC_STEPS;

	// The pipeline never pushes back.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every request yields exactly one result after the fixed latency.
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without request");

	// Reset clears the result strobe at once.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("done during reset");

endmodule

bind haversine_distance hd_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_hd_checker (.*);
